// ----- rtl/afc_pkg.sv -----
// afc_pkg: shared types and constants for the clip-space box cull unit
// widths of the corner transform, register reset values, port word types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int XY_W      = PROD_W + 1;
	localparam int CLIP_W    = PROD_W + 2;
	localparam int TEST_W    = PROD_W + 3;
	localparam int AXES      = 3;
	localparam int COMPS     = 4;
	localparam int CORNERS   = 8;
	localparam int NUM_PLANES = 6;

	// clip components
	localparam int C_X = 0;
	localparam int C_Y = 1;
	localparam int C_Z = 2;
	localparam int C_W = 3;

	// outcode bit positions
	localparam int PL_X_NEG = 0;
	localparam int PL_X_POS = 1;
	localparam int PL_Y_NEG = 2;
	localparam int PL_Y_POS = 3;
	localparam int PL_Z_NEG = 4;
	localparam int PL_Z_POS = 5;

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_regs_t;

	// identity matrix, two q16.16 entries per register
	localparam cfg_regs_t CFG_RESET = {
		64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
		64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	typedef struct packed {
		logic visible;
		logic box_invalid;
	} result_t;

	// control travelling alongside the corner data
	typedef struct packed {
		logic valid;
		logic invalid;
	} tag_t;

	typedef logic [CORNERS-1:0][COMPS-1:0][CLIP_W-1:0] clip_set_t;

	typedef logic [NUM_PLANES-1:0] outcode_t;

endpackage

`default_nettype wire

// ----- rtl/aabb_clip_space_frustum_cull_unit.sv -----
// aabb_clip_space_frustum_cull_unit: top level of the clip-space box cull
// holds the clip matrix, runs plane tests and the corner reduction
// depends on afc_pkg and afc_xform
`timescale 1ns / 1ps
`default_nettype none

// Takes one box per clock: busy is always low, so every start is accepted.
// The result word appears on result with done high for one cycle, in the order
// the boxes were started; the pipeline is s1 multiply (24 multipliers
// of 32x32), s2 and s3 partial and corner sums, s4 plane tests on all eight
// corners, s5 outcode reduction. The matrix sits in eight 64-bit registers
// written through cfg_we/cfg_index/cfg_data; write them only while no box is
// in flight. An inverted box comes out with visible low and box_invalid high.
module aabb_clip_space_frustum_cull_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire afc_pkg::box_t              box,
	input  wire logic                       cfg_we,
	input  wire logic [afc_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [afc_pkg::CFG_W-1:0]  cfg_data,
	output logic                            done,
	output afc_pkg::result_t                result
);
	import afc_pkg::*;

	cfg_regs_t mat_q;
	tag_t      tag_x;
	clip_set_t clip_x;
	outcode_t  oc_c [CORNERS];

	outcode_t  oc_s4 [CORNERS];
	tag_t      tag_s4;
	outcode_t  mask_c;
	logic      done_s5;
	result_t   result_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= CFG_RESET;
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	afc_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.box      (box),
		.mat      (mat_q),
		.out_tag  (tag_x),
		.out_clip (clip_x)
	);

	for (genvar k = 0; k < CORNERS; k++) begin : g_plane
		logic signed [TEST_W-1:0] cx, cy, cz, cw;
		assign cx = TEST_W'($signed(clip_x[k][C_X]));
		assign cy = TEST_W'($signed(clip_x[k][C_Y]));
		assign cz = TEST_W'($signed(clip_x[k][C_Z]));
		assign cw = TEST_W'($signed(clip_x[k][C_W]));
		always_comb begin
			oc_c[k]           = '0;
			oc_c[k][PL_X_NEG] = (cx + cw) < 0;
			oc_c[k][PL_X_POS] = (cx - cw) > 0;
			oc_c[k][PL_Y_NEG] = (cy + cw) < 0;
			oc_c[k][PL_Y_POS] = (cy - cw) > 0;
			oc_c[k][PL_Z_NEG] = cz < 0;
			oc_c[k][PL_Z_POS] = (cz - cw) > 0;
		end
		always_ff @(posedge clk) begin
			oc_s4[k] <= oc_c[k];
		end
	end

	always_comb begin
		mask_c = '1;
		for (int k = 0; k < CORNERS; k++) begin
			mask_c = mask_c & oc_s4[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4  <= '0;
			done_s5 <= 1'b0;
		end else begin
			tag_s4  <= tag_x;
			done_s5 <= tag_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s5.visible     <= !tag_s4.invalid && (mask_c == '0);
		result_s5.box_invalid <= tag_s4.invalid;
	end

	assign busy   = 1'b0;
	assign done   = done_s5;
	assign result = result_s5;

	// every accepted box yields exactly one word
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("box accepted without a result word");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result word without an accepted box");

	a_inv_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.box_invalid |-> !result.visible)
		else $error("invalid box reported visible");

	a_inv_flow: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s4.valid && tag_s4.invalid |=> done && result.box_invalid)
		else $error("invalid flag lost in final stage");

endmodule

`default_nettype wire

// ----- rtl/afc_xform.sv -----
// afc_xform: three-stage transform of the eight box corners into clip space
// s1 multiplies both extents of each axis by the matrix, s2 pairs partial sums,
// s3 forms each corner's clip coordinates; uses afc_pkg
`timescale 1ns / 1ps
`default_nettype none

module afc_xform (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire afc_pkg::box_t     box,
	input  wire afc_pkg::cfg_regs_t mat,
	output afc_pkg::tag_t          out_tag,
	output afc_pkg::clip_set_t     out_clip
);
	import afc_pkg::*;

	logic signed [COORD_W-1:0] lo_ax [AXES];
	logic signed [COORD_W-1:0] hi_ax [AXES];
	logic signed [COORD_W-1:0] mat_e [COMPS][COMPS];
	logic                      inv_c;

	logic signed [PROD_W-1:0]  prod_lo_s1 [AXES][COMPS];
	logic signed [PROD_W-1:0]  prod_hi_s1 [AXES][COMPS];
	logic signed [COORD_W-1:0] tr_s1 [COMPS];
	tag_t                      tag_s1;

	logic signed [XY_W-1:0]    xy_s2 [4][COMPS];
	logic signed [XY_W-1:0]    zt_s2 [2][COMPS];
	tag_t                      tag_s2;

	logic signed [CLIP_W-1:0]  clip_s3 [CORNERS][COMPS];
	tag_t                      tag_s3;

	always_comb begin
		lo_ax[0] = box.min_x;
		lo_ax[1] = box.min_y;
		lo_ax[2] = box.min_z;
		hi_ax[0] = box.max_x;
		hi_ax[1] = box.max_y;
		hi_ax[2] = box.max_z;
		inv_c = (box.min_x > box.max_x) || (box.min_y > box.max_y) ||
			(box.min_z > box.max_z);
	end

	for (genvar r = 0; r < COMPS; r++) begin : g_mat_r
		for (genvar c = 0; c < COMPS; c++) begin : g_mat_c
			assign mat_e[r][c] = $signed(mat[r*2 + c/2][(c%2)*COORD_W +: COORD_W]);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1.valid   <= in_valid;
			tag_s1.invalid <= inv_c;
			tag_s2         <= tag_s1;
			tag_s3         <= tag_s2;
		end
	end

	// s1: one multiplier per extent, axis and column
	for (genvar i = 0; i < AXES; i++) begin : g_mul_i
		for (genvar j = 0; j < COMPS; j++) begin : g_mul_j
			always_ff @(posedge clk) begin
				prod_lo_s1[i][j] <= lo_ax[i] * mat_e[i][j];
				prod_hi_s1[i][j] <= hi_ax[i] * mat_e[i][j];
			end
		end
	end

	for (genvar j = 0; j < COMPS; j++) begin : g_tr
		always_ff @(posedge clk) begin
			tr_s1[j] <= mat_e[AXES][j];
		end
	end

	// s2: x+y for the four x/y choices, z+translation for the two z choices
	for (genvar j = 0; j < COMPS; j++) begin : g_pair_j
		for (genvar m = 0; m < 4; m++) begin : g_xy
			always_ff @(posedge clk) begin
				xy_s2[m][j] <= XY_W'((m % 2 == 1) ? prod_hi_s1[0][j] : prod_lo_s1[0][j]) +
					XY_W'((m / 2 == 1) ? prod_hi_s1[1][j] : prod_lo_s1[1][j]);
			end
		end
		for (genvar n = 0; n < 2; n++) begin : g_zt
			always_ff @(posedge clk) begin
				zt_s2[n][j] <= XY_W'((n == 1) ? prod_hi_s1[2][j] : prod_lo_s1[2][j]) +
					XY_W'($signed({tr_s1[j], 16'h0}));
			end
		end
	end

	// s3: corner k takes hi on axis a when bit a of k is set
	for (genvar k = 0; k < CORNERS; k++) begin : g_corner
		for (genvar j = 0; j < COMPS; j++) begin : g_comp
			always_ff @(posedge clk) begin
				clip_s3[k][j] <= CLIP_W'(xy_s2[k % 4][j]) + CLIP_W'(zt_s2[k / 4][j]);
			end
			assign out_clip[k][j] = clip_s3[k][j];
		end
	end

	assign out_tag = tag_s3;

endmodule

`default_nettype wire
